// ===== hdl/salc_pkg.sv =====
package salc_pkg;

  localparam int ADDR_W   = 32;
  localparam int STAMP_W  = 64;
  localparam int COUNT_W  = 32;
  localparam int WAYS_W   = 3;
  localparam int OFFSET_W = 4;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_OFFSET = 1'b1;

  localparam logic [WAYS_W-1:0]   WAYS_LOG2_RST   = 3'd2;
  localparam logic [OFFSET_W-1:0] LINE_OFFSET_RST = 4'd5;

  // one tag store entry
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // controller to datapath
  typedef struct packed {
    logic clr;     // clear one row of every bank
    logic accept;  // take a new address, advance time
    logic rd;      // read one row of every bank
    logic cmp;     // tag compare, load lru leaves
    logic red;     // one level of the lru reduction
    logic wr;      // stamp the hit way or fill the victim
    logic next;    // step to the next line, advance time
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic hit;       // tag match on the row just read
    logic hit_q;     // tag match of the current lookup, held
    logic pf;        // current lookup is the next-line one
    logic tree_zero; // no reduction levels at all
    logic tree_one;  // this reduction step is the last
  } sts_t;

endpackage

// ===== hdl/salc_ctl.sv =====
module salc_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output salc_pkg::cmd_t    cmd,
  input  salc_pkg::sts_t    sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_REDUCE,
    ST_WRITE
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.rd     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.hit || sts.tree_zero) state_next = ST_WRITE;
        else state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.red = 1'b1;
        if (sts.tree_one) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.hit_q || sts.pf) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.next   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WRITE))
    else $error("result strobe without a store write");

  a_no_reduce_on_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE) |-> !sts.hit_q)
    else $error("lru reduction on a hit");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result strobes in a row");

endmodule

// ===== hdl/salc_dp.sv =====
module salc_dp #(
  parameter int TOTAL_LINES = 512,
  parameter int MAX_WAYS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  salc_pkg::cmd_t                    cmd,
  output salc_pkg::sts_t                    sts,
  input  logic [salc_pkg::ADDR_W-1:0]       address,
  input  logic                              wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [salc_pkg::CFG_W-1:0]        wr_data,
  output logic                              demand_hit,
  output logic                              prefetch_done,
  output logic                              prefetch_hit,
  output logic [salc_pkg::COUNT_W-1:0]      hit_count
);

  // lines in use, ways per set at most, banks and rows
  localparam int LB    = $clog2(TOTAL_LINES + 1) - 1;
  localparam int WB    = $clog2(MAX_WAYS + 1) - 1;
  localparam int NW    = 1 << WB;
  localparam int RB    = LB - WB;
  localparam int DEPTH = 1 << RB;
  localparam int RW    = (RB > 0) ? RB : 1;
  localparam int BW    = (WB > 0) ? WB : 1;
  localparam int SBW   = $clog2(LB + 1);
  localparam int TW    = (WB > 0) ? $clog2(WB + 1) : 1;

  localparam int AW = salc_pkg::ADDR_W;
  localparam int SW = salc_pkg::STAMP_W;

  // configuration
  logic [salc_pkg::WAYS_W-1:0]   ways_log2;
  logic [salc_pkg::OFFSET_W-1:0] line_offset_bits;

  // lookup state
  logic [AW-1:0]        addr;
  logic [SW-1:0]        time_cnt;
  logic [salc_pkg::COUNT_W-1:0] hits;
  logic                 pf;
  logic [AW-1:0]        tag_q;
  logic [RW-1:0]        row_q;
  logic [NW-1:0]        in_use_q;
  logic                 hit_q;
  logic [BW-1:0]        hit_bank_q;
  logic [RW-1:0]        clr_cnt;
  logic [TW-1:0]        tree_cnt;

  // store
  salc_pkg::line_t mem  [NW][DEPTH];
  salc_pkg::line_t rd_q [NW];

  // lru reduction registers
  logic          nd_use   [NW];
  logic [SW-1:0] nd_stamp [NW];
  logic [BW-1:0] nd_idx   [NW];

  // geometry
  logic [salc_pkg::WAYS_W-1:0] wl;
  logic [SBW-1:0]              sl;
  logic [AW-1:0]               shifted;
  logic [LB-1:0]               set_idx;
  logic [5:0]                  tag_sh;
  logic [AW-1:0]               tag;
  logic [RW-1:0]               row;
  logic [BW-1:0]               hi;
  logic [BW-1:0]               lmask;
  logic [NW-1:0]               in_use;

  // compare and write
  logic [NW-1:0]        hv;
  logic [BW-1:0]        hit_bank;
  logic [BW-1:0]        wbank;
  logic [NW-1:0]        we;
  logic [RW-1:0]        wrow;
  salc_pkg::line_t      wline;

  always_comb begin
    wl      = (ways_log2 > salc_pkg::WAYS_W'(WB)) ? salc_pkg::WAYS_W'(WB) : ways_log2;
    sl      = SBW'(LB) - SBW'(wl);
    shifted = addr >> line_offset_bits;
    set_idx = shifted[LB-1:0] & ({LB{1'b1}} >> wl);
    tag_sh  = 6'(line_offset_bits) + 6'(sl);
    tag     = addr >> tag_sh;
    row     = (RB > 0) ? set_idx[RW-1:0] : '0;
    hi      = BW'(set_idx >> RB);
    lmask   = {BW{1'b1}} >> wl;
    for (int b = 0; b < NW; b++) begin
      in_use[b] = (((BW'(b) ^ hi) & lmask) == '0);
    end
  end

  // tag compare on the row just read, lowest way first
  always_comb begin
    for (int b = 0; b < NW; b++) begin
      hv[b] = in_use_q[b] && rd_q[b].valid && (rd_q[b].tag == tag_q);
    end
    hit_bank = '0;
    for (int b = NW - 1; b >= 0; b--) begin
      if (hv[b]) hit_bank = BW'(b);
    end
  end

  always_comb begin
    wbank = hit_q ? hit_bank_q : nd_idx[0];
    we    = '0;
    wrow  = row_q;
    wline = '0;
    if (cmd.clr) begin
      we   = '1;
      wrow = clr_cnt;
    end else if (cmd.wr) begin
      we          = NW'(1) << wbank;
      wline.valid = 1'b1;
      wline.tag   = tag_q;
      wline.stamp = time_cnt;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NW; b++) begin
      if (we[b]) mem[b][wrow] <= wline;
      if (cmd.rd) rd_q[b] <= mem[b][row];
    end
  end

  // in-place pairwise minimum, one tree level per cycle
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      for (int b = 0; b < NW; b++) begin
        nd_use[b]   <= in_use_q[b];
        nd_stamp[b] <= rd_q[b].stamp;
        nd_idx[b]   <= BW'(b);
      end
    end else if (cmd.red) begin
      for (int k = 0; k < NW / 2; k++) begin
        if (nd_use[2*k] && (!nd_use[2*k+1] || nd_stamp[2*k] <= nd_stamp[2*k+1])) begin
          nd_use[k]   <= nd_use[2*k];
          nd_stamp[k] <= nd_stamp[2*k];
          nd_idx[k]   <= nd_idx[2*k];
        end else begin
          nd_use[k]   <= nd_use[2*k+1];
          nd_stamp[k] <= nd_stamp[2*k+1];
          nd_idx[k]   <= nd_idx[2*k+1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) addr <= address;
    else if (cmd.next) addr <= addr + (AW'(1) << line_offset_bits);
    if (cmd.rd) begin
      tag_q    <= tag;
      row_q    <= row;
      in_use_q <= in_use;
    end
    if (cmd.cmp) hit_bank_q <= hit_bank;
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2        <= salc_pkg::WAYS_LOG2_RST;
      line_offset_bits <= salc_pkg::LINE_OFFSET_RST;
      time_cnt         <= '0;
      hits             <= '0;
      pf               <= 1'b0;
      hit_q            <= 1'b0;
      clr_cnt          <= '0;
      tree_cnt         <= '0;
      demand_hit       <= 1'b0;
      prefetch_done    <= 1'b0;
      prefetch_hit     <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          salc_pkg::REG_WAYS_LOG2:   ways_log2        <= wr_data[salc_pkg::WAYS_W-1:0];
          salc_pkg::REG_LINE_OFFSET: line_offset_bits <= wr_data[salc_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.accept || cmd.next) time_cnt <= time_cnt + 1'b1;
      if (cmd.accept) pf <= 1'b0;
      else if (cmd.next) pf <= 1'b1;
      if (cmd.rd) tree_cnt <= TW'(WB);
      else if (cmd.red) tree_cnt <= tree_cnt - 1'b1;
      if (cmd.cmp) hit_q <= |hv;
      if (cmd.wr) begin
        if (hit_q && !pf && hits != '1) hits <= hits + 1'b1;
        if (hit_q || pf) begin
          demand_hit    <= !pf;
          prefetch_done <= pf;
          prefetch_hit  <= pf && hit_q;
        end
      end
    end
  end

  assign hit_count = hits;

  always_comb begin
    sts           = '0;
    sts.clr_last  = (clr_cnt == RW'(DEPTH - 1));
    sts.hit       = |hv;
    sts.hit_q     = hit_q;
    sts.pf        = pf;
    sts.tree_zero = (tree_cnt == '0);
    sts.tree_one  = (tree_cnt == TW'(1));
  end

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    !(demand_hit && prefetch_done))
    else $error("demand hit and prefetch reported together");

  a_pf_hit_needs_pf: assert property (@(posedge clk) disable iff (rst)
    prefetch_hit |-> prefetch_done)
    else $error("prefetch hit without a prefetch");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hits >= $past(hits))
    else $error("hit counter went down");

endmodule

// ===== hdl/set_assoc_lru_cache_with_prefetch.sv =====
// sequence: a demand hit ends after its lookup and stamp; a demand miss fills the victim and
// then runs the prefetch lookup, and each miss (demand miss, prefetch miss) first walks the
// levels of the lru reduction before its write
// a new start is taken in the cycle done is high, and not while a word is still in flight
// reset: synchronous, then a clearing pass over TOTAL_LINES / MAX_WAYS rows (32) with busy high
// results are strobed on done for one cycle; the receiver cannot stall
module set_assoc_lru_cache_with_prefetch #(
  parameter int TOTAL_LINES = 512,
  parameter int MAX_WAYS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [salc_pkg::ADDR_W-1:0]       address,
  // configuration writes
  input  logic                              wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [salc_pkg::CFG_W-1:0]        wr_data,
  // result channel
  output logic                              done,
  output logic                              demand_hit,
  output logic                              prefetch_done,
  output logic                              prefetch_hit,
  output logic [salc_pkg::COUNT_W-1:0]      hit_count
);

  // the tag store is split into MAX_WAYS banks so that every way of one set
  // sits in a bank of its own at the same row: a lookup reads one row of all
  // banks at once, compares tags in parallel, and on a miss finds the
  // least recently stamped way through a pairwise minimum tree that shares
  // one register level per cycle

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;

  // sequencing: clear pass, demand lookup, optional next-line lookup
  salc_ctl u_ctl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // tag store, geometry, lru tree, counters and result registers
  salc_dp #(
    .TOTAL_LINES (TOTAL_LINES),
    .MAX_WAYS    (MAX_WAYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .address       (address),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .demand_hit    (demand_hit),
    .prefetch_done (prefetch_done),
    .prefetch_hit  (prefetch_hit),
    .hit_count     (hit_count)
  );

endmodule

// ===== test/tag_store_checker.sv =====
`timescale 1ns / 100ps

module tag_store_checker #(
  parameter int TOTAL_LINES = 512,
  parameter int MAX_WAYS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [salc_pkg::ADDR_W-1:0]    address,
  input  logic                           wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [salc_pkg::CFG_W-1:0]     wr_data,
  input  logic                           done,
  input  logic                           demand_hit,
  input  logic                           prefetch_done,
  input  logic                           prefetch_hit,
  input  logic [salc_pkg::COUNT_W-1:0]   hit_count,
  output int                             errors,
  output int                             pending
);

  localparam int LINES_LOG2 = $clog2(TOTAL_LINES + 1) - 1;
  localparam int WAYS_LOG2  = $clog2(MAX_WAYS + 1) - 1;
  localparam int WAY_CAP    = (WAYS_LOG2 < LINES_LOG2) ? WAYS_LOG2 : LINES_LOG2;

  typedef struct packed {
    logic                         dhit;
    logic                         pdone;
    logic                         phit;
    logic [salc_pkg::COUNT_W-1:0] hits;
  } lookup_word_t;

  // mirror of the tag store
  logic                          line_ok  [TOTAL_LINES];
  logic [salc_pkg::ADDR_W-1:0]   line_tag [TOTAL_LINES];
  logic [salc_pkg::STAMP_W-1:0]  line_age [TOTAL_LINES];
  logic [salc_pkg::STAMP_W-1:0]  clock_now;
  logic [salc_pkg::COUNT_W-1:0]  hits_so_far;
  logic [salc_pkg::WAYS_W-1:0]   cfg_ways;
  logic [salc_pkg::OFFSET_W-1:0] cfg_off;

  lookup_word_t predicted_lookups[$];
  int           bad_words = 0;
  int           word_no   = 0;

  // stamp on a hit, fill the oldest way on a miss
  function automatic bit probe_line(input logic [salc_pkg::ADDR_W-1:0] a);
    int unsigned                  wl, sl, sets, row, idx, victim, w;
    logic [salc_pkg::ADDR_W-1:0]  tg;
    logic [salc_pkg::STAMP_W-1:0] best;
    wl   = (cfg_ways > WAY_CAP) ? WAY_CAP : cfg_ways;
    sl   = LINES_LOG2 - wl;
    sets = 1 << sl;
    row  = (a >> cfg_off) & (sets - 1);
    tg   = a >> (cfg_off + sl);
    for (w = 0; w < (1 << wl); w++) begin
      idx = w * sets + row;
      if (line_ok[idx] && line_tag[idx] == tg) begin
        line_age[idx] = clock_now;
        return 1'b1;
      end
    end
    victim = row;
    best   = line_age[row];
    for (w = 1; w < (1 << wl); w++) begin
      idx = w * sets + row;
      if (line_age[idx] < best) begin
        best   = line_age[idx];
        victim = idx;
      end
    end
    line_ok[victim]  = 1'b1;
    line_tag[victim] = tg;
    line_age[victim] = clock_now;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    lookup_word_t want, got;
    if (rst) begin
      for (int i = 0; i < TOTAL_LINES; i++) begin
        line_ok[i]  = 1'b0;
        line_tag[i] = '0;
        line_age[i] = '0;
      end
      clock_now   = '0;
      hits_so_far = '0;
      cfg_ways    = salc_pkg::WAYS_LOG2_RST;
      cfg_off     = salc_pkg::LINE_OFFSET_RST;
      predicted_lookups.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          salc_pkg::REG_WAYS_LOG2:   cfg_ways = wr_data[salc_pkg::WAYS_W-1:0];
          salc_pkg::REG_LINE_OFFSET: cfg_off  = wr_data[salc_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
      // results first, so a word taken at this edge never meets its own result
      if (done) begin
        got = '{demand_hit, prefetch_done, prefetch_hit, hit_count};
        word_no++;
        if (predicted_lookups.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: result word %0d arrived with nothing predicted", $realtime, word_no);
        end else begin
          want = predicted_lookups.pop_front();
          if (got !== want) begin
            bad_words++;
            if (bad_words <= 10)
              $display("%0t: word %0d dhit %b/%b pdone %b/%b phit %b/%b hits %h/%h (exp/act)",
                       $realtime, word_no, want.dhit, got.dhit, want.pdone, got.pdone,
                       want.phit, got.phit, want.hits, got.hits);
          end
        end
      end
      if (start && !busy) begin
        want = '0;
        clock_now++;
        want.dhit = probe_line(address);
        if (want.dhit) begin
          if (hits_so_far != '1) hits_so_far++;
        end else begin
          want.pdone = 1'b1;
          clock_now++;
          want.phit = probe_line(address + (32'd1 << cfg_off));
        end
        want.hits = hits_so_far;
        predicted_lookups.push_back(want);
      end
    end
    pending <= predicted_lookups.size();
    errors  <= bad_words;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int TOTAL_LINES = 512;
  localparam int MAX_WAYS    = 16;
  // quiet cycles allowed: clearing pass, longest gap and a slow lookup fit many times over
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 162;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           start    = 1'b0;
  logic                           busy;
  logic [salc_pkg::ADDR_W-1:0]    address  = '0;
  logic                           wr_en    = 1'b0;
  logic [salc_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [salc_pkg::CFG_W-1:0]     wr_data  = '0;
  logic                           done;
  logic                           demand_hit;
  logic                           prefetch_done;
  logic                           prefetch_hit;
  logic [salc_pkg::COUNT_W-1:0]   hit_count;
  int                             errors;
  int                             pending;
  int                             quiet = 0;

  // geometry the stimulus believes is loaded, used to aim addresses
  int unsigned                    cur_ways = 32'(salc_pkg::WAYS_LOG2_RST);
  int unsigned                    cur_off  = 32'(salc_pkg::LINE_OFFSET_RST);
  logic [salc_pkg::ADDR_W-1:0]    hot [8];
  logic [salc_pkg::ADDR_W-1:0]    last_addr = '0;

  // register plan per phase: ways 0 and 4 are the real extremes, 5..7 get clamped;
  // offsets cover 0, 1, 2, 5, 8, 9, 12 and the top value 15
  int unsigned plan_ways [PHASES] = '{0, 4, 7, 3, 5, 1, 6, 0, 4, 2};
  int unsigned plan_off  [PHASES] = '{2, 8, 0, 15, 1, 9, 12, 15, 2, 5};

  // opening words at the reset geometry (4 ways, 32-byte lines, 4 KiB set stride)
  logic [salc_pkg::ADDR_W-1:0] opening [19] = '{
    32'h0000_0000,  // cold miss, next line missed too
    32'h0000_0000,  // demand hit
    32'h0000_0020,  // hit on the prefetched line
    32'h0000_001F,  // last byte of line zero
    32'hFFFF_FFFF,  // next line wraps past the top to line zero
    32'hFFFF_FFE0,
    32'h8000_0000,
    32'h0000_00A0,  // fill all four ways of one set
    32'h0000_10A0,
    32'h0000_20A0,
    32'h0000_30A0,
    32'h0000_00A0,  // refresh the oldest
    32'h0000_40A0,  // evicts the 0x10a0 line
    32'h0000_10A0,  // back in, evicting 0x20a0
    32'h0000_00A0,
    32'h5555_5555,
    32'hAAAA_AAAA,
    32'h7FFF_FFFF,
    32'h0000_0001
  };

  set_assoc_lru_cache_with_prefetch #(
    .TOTAL_LINES (TOTAL_LINES),
    .MAX_WAYS    (MAX_WAYS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .address       (address),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .done          (done),
    .demand_hit    (demand_hit),
    .prefetch_done (prefetch_done),
    .prefetch_hit  (prefetch_hit),
    .hit_count     (hit_count)
  );

  tag_store_checker #(
    .TOTAL_LINES (TOTAL_LINES),
    .MAX_WAYS    (MAX_WAYS)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .address       (address),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .done          (done),
    .demand_hit    (demand_hit),
    .prefetch_done (prefetch_done),
    .prefetch_hit  (prefetch_hit),
    .hit_count     (hit_count),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: any accepted word or result restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // hold start with a word until the block takes it; start stays high on return
  task automatic issue(input logic [salc_pkg::ADDR_W-1:0] a);
    start     <= 1'b1;
    address   <= a;
    last_addr  = a;
    do @(posedge clk); while (busy);
  endtask

  // wait until every predicted result has come back
  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [salc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [salc_pkg::CFG_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // mostly addresses near a few hot lines or in their sets, plus streams and noise
  function automatic logic [salc_pkg::ADDR_W-1:0] pick_address();
    int unsigned                 roll, wl, sl;
    logic [salc_pkg::ADDR_W-1:0] base, lo_mask;
    roll    = $urandom_range(0, 99);
    wl      = (cur_ways > 4) ? 4 : cur_ways;
    sl      = 9 - wl;
    base    = hot[$urandom_range(0, 7)];
    lo_mask = (32'd1 << cur_off) - 1;
    if (roll < 45)
      return base + ($urandom_range(0, 3) << cur_off) + ($urandom & lo_mask);
    else if (roll < 70)
      // other tags of the same set, up to twice the ways, so the lru order matters
      return base + ($urandom_range(0, 2 << wl) << (cur_off + sl));
    else if (roll < 85)
      return last_addr + (32'd1 << cur_off);
    else
      return $urandom;
  endfunction

  initial begin : stimulus
    int  p, k;
    bit  lull;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // let the clearing pass finish
    do @(posedge clk); while (busy);

    foreach (opening[i]) issue(opening[i]);

    for (p = 0; p < PHASES; p++) begin
      // registers change only with the block idle; the store keeps its contents
      start <= 1'b0;
      drain();
      while (busy) @(posedge clk);
      repeat (4) @(posedge clk);
      write_reg(salc_pkg::REG_WAYS_LOG2, salc_pkg::CFG_W'(plan_ways[p]));
      write_reg(salc_pkg::REG_LINE_OFFSET, salc_pkg::CFG_W'(plan_off[p]));
      wr_en    <= 1'b0;
      cur_ways  = plan_ways[p];
      cur_off   = plan_off[p];
      foreach (hot[i]) hot[i] = $urandom;
      hot[0] = 32'hFFFF_FFFF - $urandom_range(0, 4095);  // next line wraps at the top
      lull = 1'b0;

      for (k = 0; k < PHASE_WORDS; k++) begin
        if (k % 40 == 0) lull = ($urandom_range(0, 2) == 0);
        issue(pick_address());
        if (p == 2 && k == 80) begin
          // hold off until the block has answered everything
          start <= 1'b0;
          drain();
        end else if (p != PHASES - 1 && !lull && $urandom_range(0, 3) == 0) begin
          // last phase runs back to back
          start <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    drain();
    // room for a stray extra result to show up
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
